// File: design/srs_pkg.sv
// shared constants and the arctangent table for the spinor rotation core
package srs_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int CORDIC_STEPS_DEF = 24;
    localparam int MAX_STEPS        = 32;

    // angle path width, Q2.30 with headroom for the unreduced half angle
    localparam int HW = 40;
    // cordic x and y width
    localparam int CW = 34;

    localparam logic signed [HW-1:0] Q30_TWO_PI  = 40'sd6746518852;
    localparam logic signed [HW-1:0] Q30_PI      = 40'sd3373259426;
    localparam logic signed [HW-1:0] Q30_HALF_PI = 40'sd1686629713;
    localparam logic signed [CW-1:0] Q30_GAIN    = 34'sd652032874;

    function automatic logic signed [HW-1:0] atan_q30(input logic [4:0] idx);
        logic signed [HW-1:0] v;
        unique case (idx)
            5'd0:  v = 40'sd843314857;
            5'd1:  v = 40'sd497837829;
            5'd2:  v = 40'sd263043837;
            5'd3:  v = 40'sd133525159;
            5'd4:  v = 40'sd67021687;
            5'd5:  v = 40'sd33543516;
            5'd6:  v = 40'sd16775851;
            5'd7:  v = 40'sd8388437;
            5'd8:  v = 40'sd4194283;
            5'd9:  v = 40'sd2097149;
            5'd10: v = 40'sd1048576;
            5'd11: v = 40'sd524288;
            5'd12: v = 40'sd262144;
            5'd13: v = 40'sd131072;
            5'd14: v = 40'sd65536;
            5'd15: v = 40'sd32768;
            5'd16: v = 40'sd16384;
            5'd17: v = 40'sd8192;
            5'd18: v = 40'sd4096;
            5'd19: v = 40'sd2048;
            5'd20: v = 40'sd1024;
            5'd21: v = 40'sd512;
            5'd22: v = 40'sd256;
            5'd23: v = 40'sd128;
            5'd24: v = 40'sd64;
            5'd25: v = 40'sd32;
            5'd26: v = 40'sd16;
            5'd27: v = 40'sd8;
            5'd28: v = 40'sd4;
            5'd29: v = 40'sd2;
            5'd30: v = 40'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: design/spinor_rotation_simulator_core.sv
// cayley-klein spinor rotation core, one shared multiplier under a sequencer
//
// Input channel in_valid/in_ready carries one beat per rf sample: rf_re, rf_im,
// gradient, position and the first_sample/last_sample marks. Output channel
// out_valid/out_ready carries one beat with the spinor after a last_sample beat.
// in_ready is high only while the sequencer is idle; one beat occupies it through
// the squares, the bit-serial square root, the angle reduction, the cordic loop,
// the three bit-serial divisions and sixteen multiply-adds; every product comes
// from the one shared multiplier. A zero rotation angle skips straight to the end.
// The result sits in an output register; the next beat is accepted while it
// waits. A following last_sample beat holds in its final state until
// out_ready frees the register.
// Reset (rst_n low) sets alpha to one, beta to zero, idles the sequencer
// and drops out_valid.
module spinor_rotation_simulator_core #(
    parameter int SAMPLE_WIDTH = srs_pkg::SAMPLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = srs_pkg::CORDIC_STEPS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] rf_re,
    input  logic signed [SAMPLE_WIDTH-1:0] rf_im,
    input  logic signed [SAMPLE_WIDTH-1:0] gradient,
    input  logic signed [SAMPLE_WIDTH-1:0] position,
    input  logic                           first_sample,
    input  logic                           last_sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] alpha_re,
    output logic signed [SAMPLE_WIDTH-1:0] alpha_im,
    output logic signed [SAMPLE_WIDTH-1:0] beta_re,
    output logic signed [SAMPLE_WIDTH-1:0] beta_im
);
    localparam int W         = SAMPLE_WIDTH;
    localparam int HW        = srs_pkg::HW;
    localparam int CW        = srs_pkg::CW;
    localparam int ANG_FRAC  = W - 5;
    localparam int SPIN_FRAC = W - 2;
    localparam int MW        = W + 2;
    localparam int ACCW      = 2 * MW;
    localparam int SUMW      = 2 * W + 2;
    localparam int NW        = 2 * W - 2;
    localparam int PW        = W + 1;
    localparam int NSTEPS    = (CORDIC_STEPS < srs_pkg::MAX_STEPS) ? CORDIC_STEPS
                                                                   : srs_pkg::MAX_STEPS;
    localparam int SQ_ITERS  = W + 1;
    localparam int CS_SH     = 30 - SPIN_FRAC;
    localparam int H_SH      = 29 - ANG_FRAC;
    localparam int CNT_W     = $clog2(2 * W);

    localparam logic signed [ACCW-1:0] CG_HALF   = ACCW'(1) <<< (ANG_FRAC - 1);
    localparam logic signed [ACCW-1:0] SPIN_HALF = ACCW'(1) <<< (SPIN_FRAC - 1);
    localparam logic signed [CW-1:0]   CS_HALF   = CW'((64'd1 << CS_SH) >> 1);
    localparam logic signed [ACCW-1:0] W_MAX     = ACCW'((64'd1 << (W - 1)) - 1);
    localparam logic signed [ACCW-1:0] W_MIN     = -W_MAX - ACCW'(1);
    localparam logic signed [ACCW-1:0] ONE_ACC   = ACCW'(1) <<< SPIN_FRAC;
    localparam logic signed [W-1:0]    SPIN_ONE  = W'(1) <<< SPIN_FRAC;

    typedef enum logic [4:0] {
        S_IDLE, S_PG, S_CG, S_SQ, S_SQRT, S_SQRND, S_HA, S_MOD, S_WRAP, S_FOLD,
        S_ROT, S_CS, S_DMUL, S_DINIT, S_DIV, S_DEND, S_MAC, S_COMMIT, S_FIN
    } state_t;

    // one multiply-add term: coefficient, spinor element, subtract
    typedef struct packed {
        logic [1:0] coef;
        logic [1:0] spin;
        logic       sub;
    } term_t;

    // coef: 0 al0, 1 al1, 2 be0, 3 be1; spin: 0 a0, 1 a1, 2 b0, 3 b1
    function automatic term_t term_of(input logic [3:0] j);
        term_t t;
        unique case (j)
            4'd0:  t = '{2'd0, 2'd2, 1'b0};
            4'd1:  t = '{2'd1, 2'd3, 1'b1};
            4'd2:  t = '{2'd2, 2'd0, 1'b0};
            4'd3:  t = '{2'd3, 2'd1, 1'b0};
            4'd4:  t = '{2'd0, 2'd3, 1'b0};
            4'd5:  t = '{2'd1, 2'd2, 1'b0};
            4'd6:  t = '{2'd3, 2'd0, 1'b0};
            4'd7:  t = '{2'd2, 2'd1, 1'b1};
            4'd8:  t = '{2'd0, 2'd0, 1'b0};
            4'd9:  t = '{2'd1, 2'd1, 1'b1};
            4'd10: t = '{2'd2, 2'd2, 1'b1};
            4'd11: t = '{2'd3, 2'd3, 1'b1};
            4'd12: t = '{2'd0, 2'd1, 1'b0};
            4'd13: t = '{2'd1, 2'd0, 1'b0};
            4'd14: t = '{2'd2, 2'd3, 1'b0};
            default: t = '{2'd3, 2'd2, 1'b1};
        endcase
        return t;
    endfunction

    // destination spinor element of each sum: beta_re, beta_im, alpha_re, alpha_im
    function automatic logic [1:0] dest_of(input logic [1:0] g);
        logic [1:0] d;
        unique case (g)
            2'd0: d = 2'd2;
            2'd1: d = 2'd3;
            2'd2: d = 2'd0;
            default: d = 2'd1;
        endcase
        return d;
    endfunction

    function automatic logic signed [W-1:0] sat_round(input logic signed [ACCW-1:0] v);
        logic signed [ACCW-1:0] r;
        logic signed [W-1:0]    o;
        r = (v + SPIN_HALF) >>> SPIN_FRAC;
        if (r > ONE_ACC)
            o = SPIN_ONE;
        else if (r < -ONE_ACC)
            o = -SPIN_ONE;
        else
            o = W'(r);
        return o;
    endfunction

    state_t                   state_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [1:0]               dcnt_reg;
    logic signed [W-1:0]      re_reg, im_reg, g_reg, p_reg, cg_reg;
    logic                     last_reg;
    logic signed [ACCW-1:0]   prod_reg, acc_reg;
    logic [SUMW-1:0]          rem_reg, res_reg, bit_reg;
    logic [PW-1:0]            phi_reg;
    logic signed [HW-1:0]     h_reg;
    logic                     neg_reg;
    logic signed [CW-1:0]     x_reg, y_reg;
    logic signed [MW-1:0]     sin_reg;
    logic signed [MW-1:0]     coef_reg [4];
    logic signed [W-1:0]      spin_reg [4];
    logic signed [W-1:0]      new_reg [4];
    logic [NW-1:0]            num_reg;
    logic [W+1:0]             drem_reg;
    logic [W+1:0]             quo_reg;
    logic                     dneg_reg;
    logic                     out_valid_reg;
    logic signed [W-1:0]      ar_reg, ai_reg, br_reg, bi_reg;

    logic signed [MW-1:0]     mul_a, mul_b;
    logic signed [ACCW-1:0]   mul_p;
    term_t                    tcur, tacc;
    logic [3:0]               jacc;
    logic signed [ACCW-1:0]   term_val;
    logic [SUMW-1:0]          sq_try;
    logic [W+1:0]             dtry;
    logic signed [ACCW-1:0]   cg_r;
    logic signed [CW-1:0]     xs, ys, xn, yn;
    logic signed [ACCW-1:0]   pmag;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign alpha_re  = ar_reg;
    assign alpha_im  = ai_reg;
    assign beta_re   = br_reg;
    assign beta_im   = bi_reg;

    assign tcur     = term_of(cnt_reg[3:0]);
    assign jacc     = 4'(cnt_reg - CNT_W'(1));
    assign tacc     = term_of(jacc);
    assign term_val = tacc.sub ? -prod_reg : prod_reg;
    assign sq_try   = res_reg + bit_reg;
    assign dtry     = {drem_reg[W:0], num_reg[NW-1]};
    assign cg_r     = (prod_reg + CG_HALF) >>> ANG_FRAC;
    assign xs       = x_reg >>> cnt_reg[4:0];
    assign ys       = y_reg >>> cnt_reg[4:0];
    assign xn       = neg_reg ? -x_reg : x_reg;
    assign yn       = neg_reg ? -y_reg : y_reg;
    assign pmag     = prod_reg[ACCW-1] ? -prod_reg : prod_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_PG:
            begin
                mul_a = MW'(p_reg);
                mul_b = MW'(g_reg);
            end
            S_SQ:
            begin
                unique case (cnt_reg[1:0])
                    2'd0:    mul_a = MW'(re_reg);
                    2'd1:    mul_a = MW'(im_reg);
                    default: mul_a = MW'(cg_reg);
                endcase
                mul_b = mul_a;
            end
            S_DMUL:
            begin
                unique case (dcnt_reg)
                    2'd0:    mul_a = MW'(cg_reg);
                    2'd1:    mul_a = MW'(im_reg);
                    default: mul_a = MW'(re_reg);
                endcase
                mul_b = sin_reg;
            end
            S_MAC:
            begin
                mul_a = coef_reg[tcur.coef];
                mul_b = MW'(spin_reg[tcur.spin]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            dcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
            spin_reg[0]   <= SPIN_ONE;
            spin_reg[1]   <= '0;
            spin_reg[2]   <= '0;
            spin_reg[3]   <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !(state_reg == S_FIN && last_reg))
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        re_reg   <= rf_re;
                        im_reg   <= rf_im;
                        g_reg    <= gradient;
                        p_reg    <= position;
                        last_reg <= last_sample;
                        if (first_sample)
                        begin
                            spin_reg[0] <= SPIN_ONE;
                            spin_reg[1] <= '0;
                            spin_reg[2] <= '0;
                            spin_reg[3] <= '0;
                        end
                        state_reg <= S_PG;
                    end
                end
                S_PG:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_CG;
                end
                S_CG:
                begin
                    if (cg_r > W_MAX)
                        cg_reg <= W'(W_MAX);
                    else if (cg_r < W_MIN)
                        cg_reg <= W'(W_MIN);
                    else
                        cg_reg <= W'(cg_r);
                    cnt_reg   <= '0;
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    prod_reg <= mul_p;
                    if (cnt_reg == CNT_W'(1))
                        rem_reg <= SUMW'(prod_reg);
                    else if (cnt_reg != '0)
                        rem_reg <= rem_reg + SUMW'(prod_reg);
                    if (cnt_reg == CNT_W'(3))
                    begin
                        res_reg   <= '0;
                        bit_reg   <= SUMW'(1) << (SUMW - 2);
                        cnt_reg   <= '0;
                        state_reg <= S_SQRT;
                    end
                    else
                        cnt_reg <= cnt_reg + CNT_W'(1);
                end
                S_SQRT:
                begin
                    if (rem_reg >= sq_try)
                    begin
                        rem_reg <= rem_reg - sq_try;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end
                    else
                        res_reg <= res_reg >> 1;
                    bit_reg <= bit_reg >> 2;
                    if (cnt_reg == CNT_W'(SQ_ITERS - 1))
                        state_reg <= S_SQRND;
                    else
                        cnt_reg <= cnt_reg + CNT_W'(1);
                end
                S_SQRND:
                begin
                    phi_reg <= (rem_reg > res_reg) ? PW'(res_reg + SUMW'(1)) : PW'(res_reg);
                    if (res_reg == '0 && rem_reg == '0)
                        state_reg <= S_FIN;
                    else
                        state_reg <= S_HA;
                end
                S_HA:
                begin
                    h_reg     <= HW'(phi_reg) <<< H_SH;
                    state_reg <= S_MOD;
                end
                S_MOD:
                begin
                    if (h_reg >= srs_pkg::Q30_TWO_PI)
                        h_reg <= h_reg - srs_pkg::Q30_TWO_PI;
                    else
                        state_reg <= S_WRAP;
                end
                S_WRAP:
                begin
                    if (h_reg > srs_pkg::Q30_PI)
                        h_reg <= h_reg - srs_pkg::Q30_TWO_PI;
                    state_reg <= S_FOLD;
                end
                S_FOLD:
                begin
                    if (h_reg > srs_pkg::Q30_HALF_PI)
                    begin
                        h_reg   <= h_reg - srs_pkg::Q30_PI;
                        neg_reg <= 1'b1;
                    end
                    else if (h_reg < -srs_pkg::Q30_HALF_PI)
                    begin
                        h_reg   <= h_reg + srs_pkg::Q30_PI;
                        neg_reg <= 1'b1;
                    end
                    else
                        neg_reg <= 1'b0;
                    x_reg     <= srs_pkg::Q30_GAIN;
                    y_reg     <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_ROT;
                end
                S_ROT:
                begin
                    if (!h_reg[HW-1])
                    begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        h_reg <= h_reg - srs_pkg::atan_q30(cnt_reg[4:0]);
                    end
                    else
                    begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        h_reg <= h_reg + srs_pkg::atan_q30(cnt_reg[4:0]);
                    end
                    if (cnt_reg == CNT_W'(NSTEPS - 1))
                        state_reg <= S_CS;
                    else
                        cnt_reg <= cnt_reg + CNT_W'(1);
                end
                S_CS:
                begin
                    coef_reg[0] <= MW'((xn + CS_HALF) >>> CS_SH);
                    sin_reg     <= MW'((yn + CS_HALF) >>> CS_SH);
                    dcnt_reg    <= '0;
                    state_reg   <= S_DMUL;
                end
                S_DMUL:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_DINIT;
                end
                S_DINIT:
                begin
                    num_reg   <= NW'(pmag) + NW'(phi_reg >> 1);
                    dneg_reg  <= prod_reg[ACCW-1];
                    drem_reg  <= '0;
                    quo_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (dtry >= (W+2)'(phi_reg))
                    begin
                        drem_reg <= dtry - (W+2)'(phi_reg);
                        quo_reg  <= {quo_reg[W:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= dtry;
                        quo_reg  <= {quo_reg[W:0], 1'b0};
                    end
                    num_reg <= num_reg << 1;
                    if (cnt_reg == CNT_W'(NW - 1))
                        state_reg <= S_DEND;
                    else
                        cnt_reg <= cnt_reg + CNT_W'(1);
                end
                S_DEND:
                begin
                    coef_reg[2'(dcnt_reg + 2'd1)] <= dneg_reg ? -$signed(quo_reg)
                                                              : $signed(quo_reg);
                    if (dcnt_reg == 2'd2)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_MAC;
                    end
                    else
                    begin
                        dcnt_reg  <= dcnt_reg + 2'd1;
                        state_reg <= S_DMUL;
                    end
                end
                S_MAC:
                begin
                    prod_reg <= mul_p;
                    if (cnt_reg == CNT_W'(17))
                    begin
                        new_reg[dest_of(2'd3)] <= sat_round(acc_reg);
                        state_reg              <= S_COMMIT;
                    end
                    else
                    begin
                        if (cnt_reg != '0)
                        begin
                            if (jacc[1:0] == 2'd0)
                            begin
                                acc_reg <= term_val;
                                if (jacc != 4'd0)
                                    new_reg[dest_of(2'(jacc[3:2] - 2'd1))] <= sat_round(acc_reg);
                            end
                            else
                                acc_reg <= acc_reg + term_val;
                        end
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                S_COMMIT:
                begin
                    spin_reg[0] <= new_reg[0];
                    spin_reg[1] <= new_reg[1];
                    spin_reg[2] <= new_reg[2];
                    spin_reg[3] <= new_reg[3];
                    state_reg   <= S_FIN;
                end
                S_FIN:
                begin
                    if (!last_reg)
                        state_reg <= S_IDLE;
                    else if (!out_valid_reg || out_ready)
                    begin
                        ar_reg        <= spin_reg[0];
                        ai_reg        <= spin_reg[1];
                        br_reg        <= spin_reg[2];
                        bi_reg        <= spin_reg[3];
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // busy after each accepted beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("accepted a beat while busy");

    // the real parts of the spinor state never leave the saturation range
    assert property (@(posedge clk) disable iff (!rst_n)
        (spin_reg[0] <= SPIN_ONE) && (spin_reg[0] >= -SPIN_ONE)
        && (spin_reg[2] <= SPIN_ONE) && (spin_reg[2] >= -SPIN_ONE))
        else $error("spinor out of range");

    // divisions only run with a nonzero angle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (phi_reg != '0))
        else $error("division by zero angle");

    // a pending result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(ar_reg) && $stable(bi_reg)))
        else $error("pending result lost");

endmodule

// File: test/spinor_rotation_simulator_core_tb.sv
// self-checking testbench for the spinor rotation core with a bit-exact spinor predictor
`timescale 1ns / 1ps

module spinor_rotation_simulator_core_tb;

    localparam int W = srs_pkg::SAMPLE_WIDTH_DEF;
    localparam int STEPS = (srs_pkg::CORDIC_STEPS_DEF > srs_pkg::MAX_STEPS)
                           ? srs_pkg::MAX_STEPS : srs_pkg::CORDIC_STEPS_DEF;
    localparam int ANG_FRAC = W - 5;
    localparam int SPIN_FRAC = W - 2;
    localparam longint SPIN_ONE = longint'(1) << SPIN_FRAC;
    localparam longint WMAX = (longint'(1) << (W - 1)) - 1;
    localparam longint LIMIT_CYCLES = 1500000;

    typedef struct {
        logic signed [W-1:0] rf_re;
        logic signed [W-1:0] rf_im;
        logic signed [W-1:0] gradient;
        logic signed [W-1:0] position;
        logic                first_sample;
        logic                last_sample;
    } sample_t;

    typedef struct {
        logic signed [W-1:0] alpha_re;
        logic signed [W-1:0] alpha_im;
        logic signed [W-1:0] beta_re;
        logic signed [W-1:0] beta_im;
    } spinor_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic signed [W-1:0] rf_re = '0;
    logic signed [W-1:0] rf_im = '0;
    logic signed [W-1:0] gradient = '0;
    logic signed [W-1:0] position = '0;
    logic                first_sample = 1'b0;
    logic                last_sample = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic signed [W-1:0] alpha_re;
    logic signed [W-1:0] alpha_im;
    logic signed [W-1:0] beta_re;
    logic signed [W-1:0] beta_im;

    spinor_rotation_simulator_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .rf_re(rf_re), .rf_im(rf_im), .gradient(gradient), .position(position),
        .first_sample(first_sample), .last_sample(last_sample),
        .out_valid(out_valid), .out_ready(out_ready),
        .alpha_re(alpha_re), .alpha_im(alpha_im), .beta_re(beta_re), .beta_im(beta_im)
    );

    longint atan_tab [32] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1, 0
    };

    sample_t pending_samples[$];
    spinor_t expected_spinors[$];
    longint  sp_a0 = SPIN_ONE;
    longint  sp_a1 = 0;
    longint  sp_b0 = 0;
    longint  sp_b1 = 0;
    int      mismatches = 0;
    int      beats_in = 0;
    int      spinors_out = 0;
    int      zero_angles = 0;
    int      in_gap = 0;
    int      out_stall = 0;

    function automatic longint rnd_shr(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint div_near(input longint n, input longint d);
        if (n >= 0)
            return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic longint isqrt_near(input longint unsigned v);
        longint unsigned rem, res, b;
        rem = v;
        res = 0;
        b = longint'(1) << 62;
        while (b > rem)
            b = b >> 2;
        while (b != 0)
        begin
            if (rem >= res + b)
            begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        if (rem > res)
            res = res + 1;
        return longint'(res);
    endfunction

    // advances the spinor state by one sample, returns 1 when a spinor is emitted
    function automatic bit rotate_spinor(input sample_t s, output spinor_t r);
        longint re, im, g, p, cg, phi, h, x, y, nx, ny, cs, sn;
        longint al0, al1, be0, be1, a0, a1, b0, b1;
        longint unsigned sq;
        bit neg;
        re = s.rf_re;
        im = s.rf_im;
        g = s.gradient;
        p = s.position;
        if (s.first_sample)
        begin
            sp_a0 = SPIN_ONE;
            sp_a1 = 0;
            sp_b0 = 0;
            sp_b1 = 0;
        end
        cg = clip(rnd_shr(p * g, ANG_FRAC), -WMAX - 1, WMAX);
        sq = longint'(re * re) + longint'(im * im) + longint'(cg * cg);
        phi = isqrt_near(sq);
        if (phi == 0)
            zero_angles++;
        else
        begin
            a0 = sp_a0; a1 = sp_a1; b0 = sp_b0; b1 = sp_b1;
            h = phi * (longint'(1) << (29 - ANG_FRAC));
            h = h % longint'(srs_pkg::Q30_TWO_PI);
            neg = 1'b0;
            if (h > longint'(srs_pkg::Q30_PI))
                h = h - longint'(srs_pkg::Q30_TWO_PI);
            if (h > longint'(srs_pkg::Q30_HALF_PI))
            begin
                h = h - longint'(srs_pkg::Q30_PI);
                neg = 1'b1;
            end
            else if (h < -longint'(srs_pkg::Q30_HALF_PI))
            begin
                h = h + longint'(srs_pkg::Q30_PI);
                neg = 1'b1;
            end
            x = longint'(srs_pkg::Q30_GAIN);
            y = 0;
            for (int i = 0; i < STEPS; i++)
            begin
                if (h >= 0)
                begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    h = h - atan_tab[i];
                end
                else
                begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    h = h + atan_tab[i];
                end
                x = nx;
                y = ny;
            end
            if (neg)
            begin
                x = -x;
                y = -y;
            end
            cs = rnd_shr(x, 30 - SPIN_FRAC);
            sn = rnd_shr(y, 30 - SPIN_FRAC);
            al0 = cs;
            al1 = div_near(cg * sn, phi);
            be0 = div_near(im * sn, phi);
            be1 = div_near(re * sn, phi);
            sp_b0 = clip(rnd_shr(al0*b0 - al1*b1 + be0*a0 + be1*a1, SPIN_FRAC), -SPIN_ONE, SPIN_ONE);
            sp_b1 = clip(rnd_shr(al0*b1 + al1*b0 + be1*a0 - be0*a1, SPIN_FRAC), -SPIN_ONE, SPIN_ONE);
            sp_a0 = clip(rnd_shr(al0*a0 - al1*a1 - be0*b0 - be1*b1, SPIN_FRAC), -SPIN_ONE, SPIN_ONE);
            sp_a1 = clip(rnd_shr(al0*a1 + al1*a0 + be0*b1 - be1*b0, SPIN_FRAC), -SPIN_ONE, SPIN_ONE);
        end
        r.alpha_re = sp_a0[W-1:0];
        r.alpha_im = sp_a1[W-1:0];
        r.beta_re = sp_b0[W-1:0];
        r.beta_im = sp_b1[W-1:0];
        return s.last_sample;
    endfunction

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55)
            return 0;
        if (k < 95)
            return $urandom_range(1, 4);
        return $urandom_range(20, 60);
    endfunction

    function automatic longint pick_value();
        int k;
        k = $urandom_range(0, 9);
        if (k < 3)
            return longint'($urandom);
        if (k == 3)
        begin
            case ($urandom_range(0, 4))
                0: return WMAX;
                1: return -WMAX - 1;
                2: return 0;
                3: return -1;
                default: return 1;
            endcase
        end
        return longint'($urandom_range(0, 1 << 20)) - longint'(1 << 19);
    endfunction

    function automatic sample_t make_sample(input longint re, input longint im,
                                            input longint g, input longint p,
                                            input int fs, input int ls);
        sample_t s;
        s.rf_re = re[W-1:0];
        s.rf_im = im[W-1:0];
        s.gradient = g[W-1:0];
        s.position = p[W-1:0];
        s.first_sample = fs[0];
        s.last_sample = ls[0];
        return s;
    endfunction

    initial
    begin
        forever #10 clk = ~clk;
    end

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        sample_t s;
        spinor_t r;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                beats_in++;
                s = make_sample(rf_re, rf_im, gradient, position, first_sample, last_sample);
                if (rotate_spinor(s, r))
                    expected_spinors.push_back(r);
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_gap <= in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_samples.size() > 0)
                begin
                    s = pending_samples.pop_front();
                    rf_re <= s.rf_re;
                    rf_im <= s.rf_im;
                    gradient <= s.gradient;
                    position <= s.position;
                    first_sample <= s.first_sample;
                    last_sample <= s.last_sample;
                    in_valid <= 1'b1;
                    in_gap <= pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // output monitor
    always @(posedge clk or negedge rst_n)
    begin
        spinor_t e;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_stall <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                spinors_out++;
                if (expected_spinors.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected spinor beat %0d %0d %0d %0d",
                                 alpha_re, alpha_im, beta_re, beta_im);
                end
                else
                begin
                    e = expected_spinors.pop_front();
                    if (e.alpha_re !== alpha_re || e.alpha_im !== alpha_im ||
                        e.beta_re !== beta_re || e.beta_im !== beta_im)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("spinor %0d: expected %0d %0d %0d %0d got %0d %0d %0d %0d",
                                     spinors_out, e.alpha_re, e.alpha_im, e.beta_re, e.beta_im,
                                     alpha_re, alpha_im, beta_re, beta_im);
                    end
                end
            end
            if (out_stall > 0)
            begin
                out_stall <= out_stall - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                out_stall <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
        end
    end

    initial
    begin
        int len;
        bit noise;
        // directed: zero angle, extremes, mark combinations
        pending_samples.push_back(make_sample(0, 0, 0, 0, 1, 1));
        pending_samples.push_back(make_sample(0, 0, WMAX, 0, 1, 1));
        pending_samples.push_back(make_sample(0, 0, 1, 1, 1, 1));
        pending_samples.push_back(make_sample(WMAX, 0, 0, 0, 1, 1));
        pending_samples.push_back(make_sample(-WMAX - 1, 0, 0, 0, 1, 1));
        pending_samples.push_back(make_sample(0, WMAX, 0, 0, 1, 1));
        pending_samples.push_back(make_sample(0, -WMAX - 1, 0, 0, 1, 1));
        pending_samples.push_back(make_sample(0, 0, WMAX, WMAX, 1, 1));
        pending_samples.push_back(make_sample(0, 0, -WMAX - 1, WMAX, 1, 1));
        pending_samples.push_back(make_sample(0, 0, -WMAX - 1, -WMAX - 1, 1, 1));
        pending_samples.push_back(make_sample(-WMAX - 1, -WMAX - 1, -WMAX - 1, -WMAX - 1, 1, 1));
        pending_samples.push_back(make_sample(WMAX, WMAX, WMAX, -WMAX - 1, 1, 1));
        pending_samples.push_back(make_sample(1 << 19, 0, 0, 0, 1, 0));
        pending_samples.push_back(make_sample(0, 1 << 19, 1 << 18, 1 << 19, 0, 0));
        pending_samples.push_back(make_sample(0, 0, 0, 0, 0, 0));
        pending_samples.push_back(make_sample(-1, 1, 1 << 19, -(1 << 19), 0, 1));
        pending_samples.push_back(make_sample(1647099, 0, 0, 0, 1, 1));
        pending_samples.push_back(make_sample(3294199, 0, 0, 0, 0, 1));
        pending_samples.push_back(make_sample(1, 0, 0, 0, 0, 1));
        pending_samples.push_back(make_sample(0, 0, -1, 1, 0, 1));
        // random: mostly well-formed position runs, some noise
        while (pending_samples.size() < 1220)
        begin
            noise = ($urandom_range(0, 9) == 0);
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                pending_samples.push_back(make_sample(pick_value(), pick_value(),
                    pick_value(), pick_value(),
                    noise ? $urandom_range(0, 1) : (i == 0),
                    noise ? $urandom_range(0, 1) : (i == len - 1)));
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_samples.size() == 0 && !in_valid && expected_spinors.size() == 0);
        repeat (300) @(posedge clk);
        $display("covered %0d sample beats, %0d spinor beats, %0d zero-angle samples",
                 beats_in, spinors_out, zero_angles);
        if (mismatches == 0 && expected_spinors.size() == 0)
            $display("CHECK OK");
        else
        begin
            $display("%0d mismatches, %0d spinors missing", mismatches, expected_spinors.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial
    begin
        #(LIMIT_CYCLES * 20);
        $display("timeout with %0d samples pending", pending_samples.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
